// ===== hdl/i2cteb_pkg.sv =====
package i2cteb_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_READ_BYTE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILLER_BASE     = 2'd2;

  localparam logic [6:0] OWN_ADDRESS_RST     = 7'h30;
  localparam logic [7:0] EMPTY_READ_BYTE_RST = 8'hAA;
  localparam logic [7:0] FILLER_BASE_RST     = 8'h50;

  // bit counter marks: eighth bit done, ninth (acknowledge) clock
  localparam logic [3:0] BIT_BYTE_DONE = 4'd8;
  localparam logic [3:0] BIT_ACK       = 4'd9;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_RECV = 4'b0100,
    PH_SEND = 4'b1000
  } phase_t;

  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_ADDR = 2'd1;
  localparam logic [1:0] PHASE_CODE_RECV = 2'd2;
  localparam logic [1:0] PHASE_CODE_SEND = 2'd3;

  typedef struct packed {
    logic [4:0] stored_count;
    logic [1:0] bus_phase;
    logic       data_ready;
    logic [7:0] byte_value;
    logic       byte_stored;
    logic       sda_pull_low;
  } result_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_ADDR: code = PHASE_CODE_ADDR;
      PH_RECV: code = PHASE_CODE_RECV;
      PH_SEND: code = PHASE_CODE_SEND;
      default: code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/i2c_target_echo_buffer_unit.sv =====
// I2C target with a write/read-back byte buffer, driven by pin samples.
// Input stream: one request per clock carries the sampled SCL and SDA
// levels and a clear strobe for the ready flag and byte count.
// Output stream: one result per request with the SDA pull-down, the
// received-byte strobe and value, the ready flag, bus phase and count.
// Latency: a result appears on m_tvalid the cycle after its request is
// taken. Throughput: one request per clock; the protocol step settles in
// the accepting cycle and lands in the result register at its edge, and
// the buffer memory read is registered and fetched ahead at the index the next step may need.
// When the receiver stalls, the result waits in the output register and
// s_tready drops only while that register is full and not being taken.
// Reset (rst, synchronous) returns the target to idle with SCL/SDA seen
// high, clears the count and ready flag and loads the register defaults
// (own address 0x30, empty read byte 0xAA, filler base 0x50). The buffer
// contents are not cleared; only entries below the count are read.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
// next edge and belong in idle periods of the stream.
module i2c_target_echo_buffer_unit #(
  parameter int BUFFER_DEPTH = i2cteb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: [0] scl_level, [1] sda_level, [2] clear_ready
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [i2cteb_pkg::IN_DATA_W-1:0]   s_tdata,
  // m_tdata: [0] sda_pull_low, [1] byte_stored, [9:2] byte_value,
  //          [10] data_ready, [12:11] bus_phase, [17:13] stored_count
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [i2cteb_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                               cfg_we,
  input  logic [i2cteb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cteb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cteb_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);

  logic          step;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  result_t       result;
  logic          space;

  assign s_tready = space;
  assign step     = s_tvalid && space;

  i2cteb_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2cteb_engine #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .scl       (s_tdata[0]),
    .sda       (s_tdata[1]),
    .clr       (s_tdata[2]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .result    (result)
  );

  i2cteb_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/i2cteb_store.sv =====
module i2cteb_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a write that lands on the entry being fetched
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/i2cteb_engine.sv =====
module i2cteb_engine #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int FW    = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                scl,
  input  logic                                sda,
  input  logic                                clr,
  input  logic                                cfg_we,
  input  logic [i2cteb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cteb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                          rd_data,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [7:0]                          wr_data,
  output logic [AW-1:0]                       rd_addr,
  output i2cteb_pkg::result_t                 result
);
  import i2cteb_pkg::*;

  logic [6:0] own_address;
  logic [7:0] empty_read_byte;
  logic [7:0] filler_base;

  phase_t     phase, phase_next;
  logic       scl_prev, sda_prev;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic [7:0] shift_in, shift_in_next;
  logic [7:0] shift_out, shift_out_next;
  logic [7:0] send_index, send_index_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic       ready_flag, ready_flag_next;
  logic       ack_drive, ack_drive_next;

  logic [FW-1:0] fill_eff;
  logic [7:0]    send_plus, fetch_index;
  logic          rise, fall, start_cond, stop_cond;
  logic          stored;
  logic [7:0]    value;
  logic          pull;
  logic [31:0]   count_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address     <= OWN_ADDRESS_RST;
      empty_read_byte <= EMPTY_READ_BYTE_RST;
      filler_base     <= FILLER_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:     own_address     <= cfg_data[6:0];
        CFG_EMPTY_READ_BYTE: empty_read_byte <= cfg_data;
        CFG_FILLER_BASE:     filler_base     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rise       = !scl_prev && scl;
  assign fall       = scl_prev && !scl;
  assign start_cond = scl_prev && scl && sda_prev && !sda;
  assign stop_cond  = scl_prev && scl && !sda_prev && sda;
  assign fill_eff   = clr ? '0 : fill_count;
  assign send_plus  = send_index + 8'd1;

  always_comb begin
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    shift_in_next   = shift_in;
    shift_out_next  = shift_out;
    send_index_next = send_index;
    fill_count_next = fill_count;
    ready_flag_next = ready_flag;
    ack_drive_next  = ack_drive;
    wr_en           = 1'b0;
    wr_addr         = fill_eff[AW-1:0];
    wr_data         = shift_in;
    stored          = 1'b0;
    value           = 8'd0;
    if (step) begin
      fill_count_next = fill_eff;
      if (clr) begin
        ready_flag_next = 1'b0;
      end
      if (start_cond) begin
        phase_next     = PH_ADDR;
        bit_cnt_next   = 4'd0;
        shift_in_next  = 8'd0;
        ack_drive_next = 1'b0;
      end else if (stop_cond) begin
        if ((phase == PH_RECV) && (fill_eff != '0)) begin
          ready_flag_next = 1'b1;
        end
        phase_next     = PH_IDLE;
        bit_cnt_next   = 4'd0;
        ack_drive_next = 1'b0;
      end else if ((phase == PH_ADDR) || (phase == PH_RECV)) begin
        if (rise && (bit_cnt < BIT_BYTE_DONE)) begin
          shift_in_next = {shift_in[6:0], sda};
          bit_cnt_next  = bit_cnt + 4'd1;
        end else if (fall && (bit_cnt == BIT_BYTE_DONE)) begin
          if (phase == PH_ADDR) begin
            if (shift_in[7:1] == own_address) begin
              ack_drive_next = 1'b1;
              bit_cnt_next   = BIT_ACK;
            end else begin
              phase_next   = PH_IDLE;
              bit_cnt_next = 4'd0;
            end
          end else begin
            // a full buffer still acknowledges and reports the byte
            if (9'(fill_eff) < 9'(DEPTH)) begin
              wr_en           = 1'b1;
              fill_count_next = fill_eff + FW'(1);
            end
            stored         = 1'b1;
            value          = shift_in;
            ack_drive_next = 1'b1;
            bit_cnt_next   = BIT_ACK;
          end
        end else if (fall && (bit_cnt == BIT_ACK)) begin
          ack_drive_next = 1'b0;
          bit_cnt_next   = 4'd0;
          if (phase == PH_ADDR) begin
            if (shift_in[0]) begin
              phase_next      = PH_SEND;
              send_index_next = 8'd0;
              shift_out_next  = (fill_eff != '0) ? rd_data : empty_read_byte;
            end else begin
              phase_next      = PH_RECV;
              fill_count_next = '0;
            end
          end
          shift_in_next = 8'd0;
        end
      end else if (phase == PH_SEND) begin
        if (fall && (bit_cnt < BIT_BYTE_DONE)) begin
          bit_cnt_next = bit_cnt + 4'd1;
        end else if (rise && (bit_cnt == BIT_BYTE_DONE)) begin
          if (!sda) begin
            send_index_next = send_plus;
            if ((9'(send_plus) < 9'(fill_eff)) && (9'(send_plus) < 9'(DEPTH))) begin
              shift_out_next = rd_data;
            end else begin
              shift_out_next = filler_base + send_plus;
            end
            bit_cnt_next = BIT_ACK;
          end else begin
            phase_next   = PH_IDLE;
            bit_cnt_next = 4'd0;
          end
        end else if (fall && (bit_cnt == BIT_ACK)) begin
          bit_cnt_next = 4'd0;
        end
      end
    end
  end

  // prefetch the entry the next request may need: index 0 outside a read,
  // otherwise the byte after the current one
  always_comb begin
    fetch_index = send_index_next + 8'd1;
    if (phase_next == PH_SEND) begin
      rd_addr = fetch_index[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    pull = ack_drive_next;
    if ((phase_next == PH_SEND) && (bit_cnt_next < BIT_BYTE_DONE)) begin
      if (!shift_out_next[~bit_cnt_next[2:0]]) begin
        pull = 1'b1;
      end
    end
    count_wide          = 32'(fill_count_next);
    result.sda_pull_low = pull;
    result.byte_stored  = stored;
    result.byte_value   = value;
    result.data_ready   = ready_flag_next;
    result.bus_phase    = phase_code(phase_next);
    result.stored_count = count_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      scl_prev   <= 1'b1;
      sda_prev   <= 1'b1;
      bit_cnt    <= 4'd0;
      shift_in   <= 8'd0;
      shift_out  <= 8'd0;
      send_index <= 8'd0;
      fill_count <= '0;
      ready_flag <= 1'b0;
      ack_drive  <= 1'b0;
    end else begin
      phase      <= phase_next;
      bit_cnt    <= bit_cnt_next;
      shift_in   <= shift_in_next;
      shift_out  <= shift_out_next;
      send_index <= send_index_next;
      fill_count <= fill_count_next;
      ready_flag <= ready_flag_next;
      ack_drive  <= ack_drive_next;
      if (step) begin
        scl_prev <= scl;
        sda_prev <= sda;
      end
    end
  end

endmodule

// ===== hdl/i2cteb_out_stage.sv =====
module i2cteb_out_stage (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  i2cteb_pkg::result_t                  result,
  output logic                                 space,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [i2cteb_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import i2cteb_pkg::*;

  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_DATA_W'(result);
    end
  end

endmodule

// ===== hdl/i2cteb_checker.sv =====
module i2cteb_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [i2cteb_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import i2cteb_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a received byte is only reported in the receive phase
  a_stored_in_recv: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[12:11] == PHASE_CODE_RECV))
    else $error("byte reported outside receive phase");

  // byte value is zero unless a byte was stored
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[9:2] == 8'd0))
    else $error("byte value set without stored strobe");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind i2c_target_echo_buffer_unit i2cteb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/echo_buffer_checker.sv =====
module echo_buffer_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [i2cteb_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [i2cteb_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                               cfg_we,
  input  logic [i2cteb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cteb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                 mismatches,
  output int                                 awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cteb_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH_DEF;

  logic [6:0]  own_addr;
  logic [7:0]  empty_byte;
  logic [7:0]  filler;

  logic [1:0]  phase;
  logic        prev_scl;
  logic        prev_sda;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_in;
  logic [7:0]  shift_out;
  logic [7:0]  send_idx;
  int unsigned fill_cnt;
  logic [7:0]  store [DEPTH];
  logic        ready;
  logic        ack;

  result_t     pin_status_q[$];
  int          bad_count = 0;

  // Advance the target by one pin sample and return the status it shows.
  function automatic result_t predict_pins(input logic scl, input logic sda,
                                           input logic clr);
    result_t r;
    logic    rise;
    logic    fall;
    logic    pull;
    r = '0;
    rise = !prev_scl && scl;
    fall = prev_scl && !scl;
    if (clr) begin
      ready = 1'b0;
      fill_cnt = 0;
    end
    if (prev_scl && scl && prev_sda && !sda) begin
      phase = PHASE_CODE_ADDR;
      bit_cnt = '0;
      shift_in = '0;
      ack = 1'b0;
    end else if (prev_scl && scl && !prev_sda && sda) begin
      if (phase == PHASE_CODE_RECV && fill_cnt > 0) ready = 1'b1;
      phase = PHASE_CODE_IDLE;
      bit_cnt = '0;
      ack = 1'b0;
    end else if (phase == PHASE_CODE_ADDR || phase == PHASE_CODE_RECV) begin
      if (rise && bit_cnt < BIT_BYTE_DONE) begin
        shift_in = {shift_in[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
      end else if (fall && bit_cnt == BIT_BYTE_DONE) begin
        if (phase == PHASE_CODE_ADDR) begin
          if (shift_in[7:1] == own_addr) begin
            ack = 1'b1;
            bit_cnt = BIT_ACK;
          end else begin
            phase = PHASE_CODE_IDLE;
            bit_cnt = '0;
          end
        end else begin
          // past the buffer end: acknowledge and report, but drop
          if (fill_cnt < DEPTH) begin
            store[fill_cnt] = shift_in;
            fill_cnt++;
          end
          r.byte_stored = 1'b1;
          r.byte_value = shift_in;
          ack = 1'b1;
          bit_cnt = BIT_ACK;
        end
      end else if (fall && bit_cnt == BIT_ACK) begin
        ack = 1'b0;
        bit_cnt = '0;
        if (phase == PHASE_CODE_ADDR) begin
          if (shift_in[0]) begin
            phase = PHASE_CODE_SEND;
            send_idx = '0;
            shift_out = (fill_cnt > 0) ? store[0] : empty_byte;
          end else begin
            phase = PHASE_CODE_RECV;
            fill_cnt = 0;
          end
        end
        shift_in = '0;
      end
    end else if (phase == PHASE_CODE_SEND) begin
      if (fall && bit_cnt < BIT_BYTE_DONE) begin
        bit_cnt = bit_cnt + 4'd1;
      end else if (rise && bit_cnt == BIT_BYTE_DONE) begin
        if (!sda) begin
          send_idx = send_idx + 8'd1;
          if (send_idx < fill_cnt && send_idx < DEPTH) shift_out = store[send_idx];
          else shift_out = filler + send_idx;
          bit_cnt = BIT_ACK;
        end else begin
          phase = PHASE_CODE_IDLE;
          bit_cnt = '0;
        end
      end else if (fall && bit_cnt == BIT_ACK) begin
        bit_cnt = '0;
      end
    end
    prev_scl = scl;
    prev_sda = sda;

    pull = ack;
    if (phase == PHASE_CODE_SEND && bit_cnt < BIT_BYTE_DONE) begin
      if (!shift_out[3'(4'd7 - bit_cnt)]) pull = 1'b1;
    end
    r.sda_pull_low = pull;
    r.data_ready = ready;
    r.bus_phase = phase;
    r.stored_count = 5'(fill_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      own_addr = OWN_ADDRESS_RST;
      empty_byte = EMPTY_READ_BYTE_RST;
      filler = FILLER_BASE_RST;
      phase = PHASE_CODE_IDLE;
      prev_scl = 1'b1;
      prev_sda = 1'b1;
      bit_cnt = '0;
      shift_in = '0;
      shift_out = '0;
      send_idx = '0;
      fill_cnt = 0;
      ready = 1'b0;
      ack = 1'b0;
      pin_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS:     own_addr = cfg_data[6:0];
          CFG_EMPTY_READ_BYTE: empty_byte = cfg_data;
          CFG_FILLER_BASE:     filler = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (pin_status_q.size() == 0) begin
          if (bad_count < 10) $display("unexpected status %h with nothing outstanding", got);
          bad_count++;
        end else begin
          want = pin_status_q.pop_front();
          if (got.sda_pull_low !== want.sda_pull_low ||
              got.byte_stored  !== want.byte_stored  ||
              got.byte_value   !== want.byte_value   ||
              got.data_ready   !== want.data_ready   ||
              got.bus_phase    !== want.bus_phase    ||
              got.stored_count !== want.stored_count) begin
            if (bad_count < 10) begin
              $display("status mismatch, expected pull=%b stored=%b value=%h ready=%b",
                       want.sda_pull_low, want.byte_stored, want.byte_value,
                       want.data_ready);
              $display("  expected phase=%0d count=%0d, got pull=%b stored=%b value=%h",
                       want.bus_phase, want.stored_count, got.sda_pull_low,
                       got.byte_stored, got.byte_value);
              $display("  got ready=%b phase=%0d count=%0d",
                       got.data_ready, got.bus_phase, got.stored_count);
            end
            bad_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pin_status_q.push_back(predict_pins(s_tdata[0], s_tdata[1], s_tdata[2]));
    end
    mismatches <= bad_count;
    awaiting <= pin_status_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cteb_pkg::*;

  localparam int TOTAL_SAMPLES = 1750;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // s_tdata: [0] scl_level, [1] sda_level, [2] clear_ready
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // m_tdata: [0] sda_pull_low, [1] byte_stored, [9:2] byte_value,
  //          [10] data_ready, [12:11] bus_phase, [17:13] stored_count
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_OWN_ADDRESS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     awaiting;

  logic       cur_scl = 1'b1;
  logic       cur_sda = 1'b1;
  logic [6:0] tgt_addr = OWN_ADDRESS_RST;
  int         clear_permille = 0;
  int         samples_sent = 0;
  bit         fast_bits = 1'b0;
  bit         calm = 1'b0;

  i2c_target_echo_buffer_unit u_top (.*);

  echo_buffer_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 26);
  end

  task automatic put_sample(input logic scl, input logic sda, input logic clr);
    while (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'({clr, sda, scl});
    do @(posedge clk); while (!s_tready);
    cur_scl = scl;
    cur_sda = sda;
    samples_sent++;
  endtask

  task automatic drive_pins(input logic scl, input logic sda);
    put_sample(scl, sda, $urandom_range(999) < clear_permille);
  endtask

  // Change SDA only while SCL is low so no START or STOP slips in.
  task automatic bus_bit(input logic b);
    int lo;
    int hi;
    lo = (fast_bits || $urandom_range(3) != 0) ? 1 : $urandom_range(2, 4);
    hi = (fast_bits || $urandom_range(3) != 0) ? 1 : $urandom_range(2, 4);
    if (cur_scl) drive_pins(1'b0, cur_sda);
    repeat (lo) drive_pins(1'b0, b);
    repeat (hi) drive_pins(1'b1, b);
  endtask

  task automatic bus_byte(input logic [7:0] val, input logic ack_bit);
    for (int i = 7; i >= 0; i--) bus_bit(val[i]);
    bus_bit(ack_bit);
  endtask

  task automatic bus_start();
    if (cur_scl) drive_pins(1'b0, cur_sda);
    drive_pins(1'b0, 1'b1);
    drive_pins(1'b1, 1'b1);
    drive_pins(1'b1, 1'b0);
  endtask

  task automatic bus_stop(input logic clr_last);
    if (cur_scl) drive_pins(1'b0, cur_sda);
    drive_pins(1'b0, 1'b0);
    drive_pins(1'b1, 1'b0);
    put_sample(1'b1, 1'b1, clr_last);
  endtask

  // Reads ACK every byte but the last one, which the master NACKs.
  task automatic bus_transfer(input logic [6:0] addr, input logic rd, input int nbytes);
    bus_start();
    bus_byte({addr, rd}, 1'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      if (rd) bus_byte(8'($urandom), i == nbytes - 1);
      else bus_byte(($urandom_range(3) == 0) ? {8{1'($urandom)}} : 8'($urandom),
                    1'($urandom));
    end
  endtask

  task automatic random_transfer();
    logic [6:0] addr;
    int         n;
    int         pick;
    addr = ($urandom_range(99) < 85) ? tgt_addr : 7'($urandom);
    pick = $urandom_range(99);
    n = (pick < 70) ? $urandom_range(0, 4) :
        (pick < 95) ? $urandom_range(5, 12) : $urandom_range(13, 20);
    bus_transfer(addr, 1'($urandom), n);
    pick = $urandom_range(99);
    if (pick < 75) begin
      bus_stop($urandom_range(9) == 0);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) drive_pins(1'($urandom), 1'($urandom));
      bus_stop(1'b0);
    end
    // otherwise leave the bus busy so the next transfer opens with a repeated START
  endtask

  // Hold the sender until every outstanding status has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] addr, input logic [7:0] empty_val,
                            input logic [7:0] base);
    write_reg(CFG_OWN_ADDRESS, CFG_DATA_W'(addr));
    write_reg(CFG_EMPTY_READ_BYTE, empty_val);
    write_reg(CFG_FILLER_BASE, base);
    tgt_addr = addr;
  endtask

  initial begin
    int stop_at;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    fast_bits = 1'b1;
    // read from an empty buffer: empty byte first, then filler
    bus_transfer(OWN_ADDRESS_RST, 1'b1, 3);
    bus_stop(1'b0);
    // address that is not ours
    bus_transfer(OWN_ADDRESS_RST ^ 7'h01, 1'b0, 1);
    bus_stop(1'b0);
    bus_start();
    bus_byte({OWN_ADDRESS_RST, 1'b0}, 1'b0);
    bus_byte(8'h00, 1'b0);
    bus_byte(8'hFF, 1'b0);
    bus_byte(8'h5A, 1'b1);
    bus_stop(1'b0);
    // stored bytes, then filler past the count
    bus_transfer(OWN_ADDRESS_RST, 1'b1, 5);
    bus_stop(1'b0);
    put_sample(1'b1, 1'b1, 1'b1);
    // overflow the buffer, then clear on the STOP sample
    bus_transfer(OWN_ADDRESS_RST, 1'b0, 17);
    bus_stop(1'b1);
    bus_transfer(OWN_ADDRESS_RST, 1'b0, 2);
    bus_transfer(OWN_ADDRESS_RST, 1'b1, 3);
    bus_stop(1'b0);
    // STOP in the middle of the address
    bus_start();
    repeat (3) bus_bit(1'b1);
    bus_stop(1'b0);
    bus_transfer(OWN_ADDRESS_RST, 1'b0, 0);
    bus_stop(1'b0);
    bus_transfer(OWN_ADDRESS_RST, 1'b0, 1);
    bus_stop(1'b0);
    // START while the target is sending
    bus_start();
    bus_byte({OWN_ADDRESS_RST, 1'b1}, 1'b0);
    bus_byte(8'hFF, 1'b0);
    repeat (4) bus_bit(1'b1);
    bus_transfer(OWN_ADDRESS_RST, 1'b0, 1);
    bus_stop(1'b0);
    bus_transfer(OWN_ADDRESS_RST, 1'b1, 1);
    bus_stop(1'b0);
    fast_bits = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(7'h00, 8'h00, 8'h00);
        1: set_config(7'h7F, 8'hFF, 8'hFF);
        default: set_config(7'($urandom), 8'($urandom), 8'($urandom));
      endcase
      calm = (ph == 2);
      clear_permille = 4;
      // split what is left of the sample budget over the remaining phases
      stop_at = samples_sent + (TOTAL_SAMPLES - samples_sent) / (4 - ph);
      do begin
        pick = $urandom_range(99);
        if (pick < 5) put_sample(1'b1, 1'b1, 1'b1);
        else if (pick < 10)
          repeat ($urandom_range(1, 8)) drive_pins(1'($urandom), 1'($urandom));
        else random_transfer();
      end while (samples_sent < stop_at);
      bus_stop(1'b0);
    end
    calm = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("i2c_target_echo_buffer_unit test passed");
    end else begin
      $display("i2c_target_echo_buffer_unit test failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("i2c_target_echo_buffer_unit test failed");
    $finish;
  end

endmodule
